// ===== sv/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on the rising clock, off while reset is low
`define HCB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// ===== sv/hcb_pkg.sv =====
// types and constants of the hit cluster builder
package hcb_pkg;

  localparam int MaxMembers = 32;
  localparam int DeadN      = 5;
  localparam int PadW       = 8;
  localparam int ChargeW    = 12;
  localparam int TimeW      = 32;
  localparam int TotalW     = 18;
  localparam int CntW       = 6;
  localparam int AddrW      = $clog2(MaxMembers);
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;
  localparam int EntryW     = PadW + ChargeW;

  typedef struct packed {
    logic [PadW-1:0]    hit_pad;
    logic [ChargeW-1:0] hit_charge;
    logic [TimeW-1:0]   hit_time;
  } hit_t;

  typedef struct packed {
    logic [8:0]        median_pad_half;
    logic [TotalW-1:0] total_charge;
    logic [CntW-1:0]   member_count;
    logic [2:0]        filled_count;
    logic              overflow_flag;
  } result_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPosThr, CfgTimeThr, CfgMinSize, CfgDeadA, CfgDeadB, CfgDeadC, CfgDeadD, CfgDeadE
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OpNone, OpInit, OpScan, OpNb, OpFill, OpSelInit, OpCnt, OpBitEnd, OpFinish
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] addr;
    logic [2:0]       bitsel;
  } cmd_t;

  typedef struct packed {
    logic            brk;
    logic [CntW-1:0] n;
    logic            fill_en;
    logic            out_free;
  } status_t;

endpackage

// ===== sv/hcb_ram.sv =====
// generic single-port-write ram with registered read
module hcb_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/hcb_datapath.sv =====
// cluster store, configuration registers, accumulators and result register
module hcb_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_fire_i,
  input  hcb_pkg::hit_t                  in_data_i,
  input  logic                           cfg_we_i,
  input  logic [hcb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [hcb_pkg::CfgDataW-1:0]   cfg_data_i,
  input  hcb_pkg::cmd_t                  cmd_i,
  output hcb_pkg::status_t               status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output hcb_pkg::result_t               out_data_o
);
  import hcb_pkg::*;

  logic [PadW-1:0]   pos_thr_q;
  logic [15:0]       time_thr_q;
  logic [CntW-1:0]   min_size_q;
  logic [PadW-1:0]   dead_q [DeadN];

  logic              seen_q, dropped_q;
  logic [CntW-1:0]   total_q;
  logic [PadW-1:0]   last_pad_q;
  logic [TimeW-1:0]  last_time_q;
  hit_t              pend_q;
  cmd_t              cmd_q;

  logic [TotalW-1:0] sum_q;
  logic [CntW-1:0]   knz_q;
  logic [DeadN-1:0]  pres_q;
  logic [PadW-1:0]   pad0_q;
  logic [ChargeW-1:0] prev_q;
  logic [2:0]        fcnt_q;
  logic [PadW-1:0]   fpad_q [DeadN];
  logic [CntW-1:0]   r_lo_q, r_hi_q, c_lo_q, c_hi_q;
  logic [PadW-1:0]   pre_lo_q, pre_hi_q;

  logic              out_valid_q;
  result_t           out_q;

  logic [PadW-1:0]    pad_diff;
  logic [TimeW-1:0]   time_diff;
  logic               join_hit;
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [EntryW-1:0]  ram_wdata, ram_rdata;
  logic [PadW-1:0]    rd_pad;
  logic [ChargeW-1:0] rd_chg;

  logic [PadW-1:0]    bestd, dd;
  logic [PadW-1:0]    best;
  logic [2:0]         best_i;
  logic               dup, fill_take;
  logic [ChargeW:0]   fill_sum;
  logic [PadW-1:0]    hmask;
  logic               el_lo, el_hi;
  logic [CntW-1:0]    fc_lo, fc_hi, t_lo, t_hi;
  logic [8:0]         med;

  function automatic logic [TotalW-1:0] sat_add(logic [TotalW-1:0] a, logic [ChargeW-1:0] c);
    logic [TotalW:0] s;
    s = {1'b0, a} + {{(TotalW + 1 - ChargeW){1'b0}}, c};
    return s[TotalW] ? {TotalW{1'b1}} : s[TotalW-1:0];
  endfunction

  assign pad_diff  = (in_data_i.hit_pad >= last_pad_q) ? in_data_i.hit_pad - last_pad_q
                                                       : last_pad_q - in_data_i.hit_pad;
  assign time_diff = (in_data_i.hit_time >= last_time_q) ? in_data_i.hit_time - last_time_q
                                                         : last_time_q - in_data_i.hit_time;
  assign join_hit  = (pad_diff <= pos_thr_q) && (time_diff <= {16'b0, time_thr_q});

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = {in_data_i.hit_pad, in_data_i.hit_charge};
    if (in_fire_i && !seen_q) begin
      ram_we = 1'b1;
    end else if (in_fire_i && join_hit && (total_q < CntW'(MaxMembers))) begin
      ram_we    = 1'b1;
      ram_waddr = total_q[AddrW-1:0];
    end else if (cmd_q.op == OpFinish) begin
      ram_we    = 1'b1;
      ram_wdata = {pend_q.hit_pad, pend_q.hit_charge};
    end
  end

  hcb_ram #(.Width(EntryW), .Depth(MaxMembers)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cmd_i.addr),
    .rdata_o (ram_rdata)
  );

  assign rd_pad = ram_rdata[EntryW-1:ChargeW];
  assign rd_chg = ram_rdata[ChargeW-1:0];

  // nearest dead pad, ties to the earlier register
  always_comb begin
    best   = dead_q[0];
    best_i = '0;
    bestd  = (rd_pad >= dead_q[0]) ? rd_pad - dead_q[0] : dead_q[0] - rd_pad;
    for (int i = 1; i < DeadN; i++) begin
      dd = (rd_pad >= dead_q[i]) ? rd_pad - dead_q[i] : dead_q[i] - rd_pad;
      if (dd < bestd) begin
        bestd  = dd;
        best   = dead_q[i];
        best_i = 3'(i);
      end
    end
    dup = 1'b0;
    for (int m = 0; m < DeadN; m++) begin
      if ((3'(m) < fcnt_q) && (fpad_q[m] == best)) dup = 1'b1;
    end
    fill_take = (bestd <= PadW'(1)) && !pres_q[best_i] && !dup;
  end

  assign fill_sum = {1'b0, rd_chg} + {1'b0, prev_q};

  // radix select: bits above the current one must match the prefix
  assign hmask = ~(8'hFF >> (3'd7 - cmd_q.bitsel));
  assign el_lo = (rd_pad != '0) && (((rd_pad ^ pre_lo_q) & hmask) == '0) && !rd_pad[cmd_q.bitsel];
  assign el_hi = (rd_pad != '0) && (((rd_pad ^ pre_hi_q) & hmask) == '0) && !rd_pad[cmd_q.bitsel];

  always_comb begin
    fc_lo = '0;
    fc_hi = '0;
    for (int m = 0; m < DeadN; m++) begin
      if ((3'(m) < fcnt_q) && (fpad_q[m] != '0) && !fpad_q[m][cmd_q.bitsel]) begin
        if (((fpad_q[m] ^ pre_lo_q) & hmask) == '0) fc_lo = fc_lo + 1'b1;
        if (((fpad_q[m] ^ pre_hi_q) & hmask) == '0) fc_hi = fc_hi + 1'b1;
      end
    end
    t_lo = c_lo_q + fc_lo;
    t_hi = c_hi_q + fc_hi;
  end

  always_comb begin
    if (total_q == CntW'(1)) begin
      med = {pad0_q, 1'b0};
    end else if (knz_q == '0) begin
      med = '0;
    end else begin
      med = {1'b0, pre_lo_q} + {1'b0, pre_hi_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_thr_q   <= PadW'(10);
      time_thr_q  <= 16'd500;
      min_size_q  <= CntW'(4);
      dead_q[0]   <= PadW'(17);
      dead_q[1]   <= PadW'(19);
      dead_q[2]   <= PadW'(21);
      dead_q[3]   <= PadW'(74);
      dead_q[4]   <= PadW'(160);
      seen_q      <= 1'b0;
      dropped_q   <= 1'b0;
      total_q     <= '0;
      last_pad_q  <= '0;
      last_time_q <= '0;
      cmd_q       <= '{op: OpNone, addr: '0, bitsel: '0};
      out_valid_q <= 1'b0;
    end else begin
      cmd_q <= cmd_i;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgPosThr:  pos_thr_q  <= cfg_data_i[PadW-1:0];
          CfgTimeThr: time_thr_q <= cfg_data_i;
          CfgMinSize: min_size_q <= cfg_data_i[CntW-1:0];
          CfgDeadA:   dead_q[0]  <= cfg_data_i[PadW-1:0];
          CfgDeadB:   dead_q[1]  <= cfg_data_i[PadW-1:0];
          CfgDeadC:   dead_q[2]  <= cfg_data_i[PadW-1:0];
          CfgDeadD:   dead_q[3]  <= cfg_data_i[PadW-1:0];
          CfgDeadE:   dead_q[4]  <= cfg_data_i[PadW-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (in_fire_i) begin
        last_pad_q  <= in_data_i.hit_pad;
        last_time_q <= in_data_i.hit_time;
        if (!seen_q) begin
          seen_q    <= 1'b1;
          total_q   <= CntW'(1);
          dropped_q <= 1'b0;
        end else if (join_hit) begin
          if (total_q < CntW'(MaxMembers)) total_q <= total_q + 1'b1;
          else dropped_q <= 1'b1;
        end
      end
      if (cmd_q.op == OpFinish) begin
        out_valid_q <= 1'b1;
        total_q     <= CntW'(1);
        dropped_q   <= 1'b0;
      end
    end
  end

  // accumulators and payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire_i) pend_q <= in_data_i;
    case (cmd_q.op)
      OpInit: begin
        sum_q  <= '0;
        knz_q  <= '0;
        pres_q <= '0;
        fcnt_q <= '0;
      end
      OpScan: begin
        sum_q <= sat_add(sum_q, rd_chg);
        if (rd_pad != '0) knz_q <= knz_q + 1'b1;
        if (cmd_q.addr == '0) pad0_q <= rd_pad;
        for (int i = 0; i < DeadN; i++) begin
          if (rd_pad == dead_q[i]) pres_q[i] <= 1'b1;
        end
      end
      OpNb: prev_q <= rd_chg;
      OpFill: begin
        prev_q <= rd_chg;
        if (fill_take) begin
          fpad_q[fcnt_q] <= best;
          fcnt_q         <= fcnt_q + 1'b1;
          sum_q          <= sat_add(sum_q, fill_sum[ChargeW:1]);
          if (best != '0) knz_q <= knz_q + 1'b1;
        end
      end
      OpSelInit: begin
        r_hi_q   <= knz_q >> 1;
        r_lo_q   <= knz_q[0] ? (knz_q >> 1) : (knz_q >> 1) - 1'b1;
        pre_lo_q <= '0;
        pre_hi_q <= '0;
        c_lo_q   <= '0;
        c_hi_q   <= '0;
      end
      OpCnt: begin
        if (el_lo) c_lo_q <= c_lo_q + 1'b1;
        if (el_hi) c_hi_q <= c_hi_q + 1'b1;
      end
      OpBitEnd: begin
        if (r_lo_q >= t_lo) begin
          pre_lo_q[cmd_q.bitsel] <= 1'b1;
          r_lo_q <= r_lo_q - t_lo;
        end
        if (r_hi_q >= t_hi) begin
          pre_hi_q[cmd_q.bitsel] <= 1'b1;
          r_hi_q <= r_hi_q - t_hi;
        end
        c_lo_q <= '0;
        c_hi_q <= '0;
      end
      OpFinish: begin
        out_q.median_pad_half <= med;
        out_q.total_charge    <= sum_q;
        out_q.member_count    <= total_q + CntW'(fcnt_q);
        out_q.filled_count    <= fcnt_q;
        out_q.overflow_flag   <= dropped_q;
      end
      default: ;
    endcase
  end

  assign status_o.brk      = seen_q && !join_hit;
  assign status_o.n        = total_q;
  assign status_o.fill_en  = (total_q >= CntW'(2)) && (total_q >= min_size_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
endmodule

// ===== sv/hcb_ctrl.sv =====
// sequencer for the cluster close: scan, dead pad fill, median select, result
module hcb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hcb_pkg::status_t status_i,
  output hcb_pkg::cmd_t    cmd_o
);
  import hcb_pkg::*;

  typedef enum logic [2:0] {
    SIdle, SScan, SFill, SSelInit, SSelCnt, SSelEnd, SOut, SWrap
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] idx_q;
  logic [2:0]      bit_q;
  logic            nb_q;
  logic            last_idx;

  assign last_idx   = (idx_q == status_i.n - 1'b1);
  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    cmd_o = '{op: OpNone, addr: idx_q[AddrW-1:0], bitsel: bit_q};
    unique case (state_q)
      SIdle:    if (in_valid_i && status_i.brk) cmd_o.op = OpInit;
      SScan:    cmd_o.op = OpScan;
      SFill: begin
        if (nb_q) begin
          cmd_o.op   = OpNb;
          cmd_o.addr = AddrW'(1);
        end else begin
          cmd_o.op = OpFill;
        end
      end
      SSelInit: cmd_o.op = OpSelInit;
      SSelCnt:  cmd_o.op = OpCnt;
      SSelEnd:  cmd_o.op = OpBitEnd;
      SOut:     if (status_i.out_free) cmd_o.op = OpFinish;
      SWrap:    cmd_o.op = OpNone;
      default:  cmd_o.op = OpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= '0;
      bit_q   <= '0;
      nb_q    <= 1'b0;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (in_valid_i && status_i.brk) begin
            state_q <= SScan;
            idx_q   <= '0;
          end
        end
        SScan: begin
          if (last_idx) begin
            idx_q   <= '0;
            nb_q    <= 1'b1;
            state_q <= status_i.fill_en ? SFill : SSelInit;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        SFill: begin
          // first member's neighbour is read ahead of it
          if (nb_q) begin
            nb_q <= 1'b0;
          end else if (last_idx) begin
            idx_q   <= '0;
            state_q <= SSelInit;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        SSelInit: begin
          idx_q   <= '0;
          bit_q   <= 3'd7;
          state_q <= SSelCnt;
        end
        SSelCnt: begin
          if (last_idx) state_q <= SSelEnd;
          else idx_q <= idx_q + 1'b1;
        end
        SSelEnd: begin
          idx_q <= '0;
          if (bit_q == '0) begin
            state_q <= SOut;
          end else begin
            bit_q   <= bit_q - 1'b1;
            state_q <= SSelCnt;
          end
        end
        SOut:  if (status_i.out_free) state_q <= SWrap;
        SWrap: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== sv/hit_cluster_builder_top.sv =====
// Hit cluster builder: hits that lie within the pad and time thresholds of the previous hit
// form a cluster; a hit outside them closes the cluster and emits one result beat, then seeds
// the next cluster. A hit that joins or seeds is taken at once. A hit that closes a cluster
// of n stored members (n up to 32) is taken at once and holds off the next hit while the
// member scan, the dead pad fill when it applies, and the eight bit passes of the median select
// each walk the member store through its single read port. The result sits in an output
// register, so the next hit is taken while it waits; a later close stalls at its end until that
// register is free.
module hit_cluster_builder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  hcb_pkg::hit_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output hcb_pkg::result_t             out_data_o,
  input  logic                         cfg_we_i,
  input  logic [hcb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hcb_pkg::CfgDataW-1:0] cfg_data_i
);
  import hcb_pkg::*;

  cmd_t    cmd;
  status_t status;

  hcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hcb_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_valid_i && in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );
endmodule

// ===== sv/hcb_checker.sv =====
// port-level checks of the cluster builder and their bind
`include "assert_macros.svh"

module hcb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input hcb_pkg::hit_t                in_data_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input hcb_pkg::result_t             out_data_o,
  input logic                         cfg_we_i,
  input logic [hcb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [hcb_pkg::CfgDataW-1:0] cfg_data_i
);
  import hcb_pkg::*;

  // stalled result beat holds
  `HCB_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result beat changed while stalled")
  `HCB_ASSERT(a_fill_max, out_valid_o |-> out_data_o.filled_count <= 3'd5, "too many filled pads")
  `HCB_ASSERT(a_count_rng, out_valid_o |-> out_data_o.member_count > CntW'(out_data_o.filled_count) && out_data_o.member_count <= CntW'(37), "member count out of range")
  // filling needs at least two real members
  `HCB_ASSERT(a_fill_size, out_valid_o && out_data_o.filled_count != 3'd0 |-> out_data_o.member_count >= CntW'(out_data_o.filled_count) + CntW'(2), "fill on small cluster")
endmodule

bind hit_cluster_builder_top hcb_checker u_hcb_checker (.*);

// ===== tb/hcb_checker.sv =====
// result checker for the hit cluster builder: tracks hits and register writes, predicts and compares
`timescale 1ns / 100ps

module hcb_result_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  hcb_pkg::hit_t                in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  hcb_pkg::result_t             out_data_i,
  input  logic                         cfg_we_i,
  input  logic [hcb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hcb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         drain_i,
  output int                           pending_o,
  output int                           fail_count_o
);
  import hcb_pkg::*;

  localparam int StoreN   = MaxMembers + DeadN;
  localparam int TotalMax = 262143;

  logic [7:0]  pos_thr;
  logic [15:0] time_thr;
  logic [5:0]  min_size;
  logic [7:0]  dead_pad [DeadN];

  logic [7:0]  prev_pad;
  logic [31:0] prev_time;
  bit          started;
  int          n_members;
  bit          dropped;
  logic [7:0]  store_pad [MaxMembers];
  logic [11:0] store_chg [MaxMembers];

  result_t expected_q[$];
  result_t seen_q[$];
  int      fails;

  assign fail_count_o = fails;

  function automatic int unsigned gap(int unsigned a, int unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic result_t cluster_summary();
    int unsigned p[StoreN];
    int unsigned c[StoreN];
    int unsigned srt[StoreN];
    int unsigned best, bestd, d, total, med, v;
    int n, cnt, filled, k, nb, pos;
    bit present;
    result_t r;
    n = n_members > MaxMembers ? MaxMembers : n_members;
    for (int i = 0; i < n; i++) begin
      p[i] = store_pad[i];
      c[i] = store_chg[i];
    end
    cnt = n;
    filled = 0;
    if (n >= 2 && n >= min_size) begin
      for (int j = 0; j < n; j++) begin
        best = dead_pad[0];
        bestd = gap(p[j], dead_pad[0]);
        for (int i = 1; i < DeadN; i++) begin
          d = gap(p[j], dead_pad[i]);
          if (d < bestd) begin
            bestd = d;
            best = dead_pad[i];
          end
        end
        if (bestd > 1) continue;
        present = 0;
        for (int i = 0; i < cnt; i++) if (p[i] == best) present = 1;
        if (present || cnt >= StoreN) continue;
        nb = (j == 0) ? 1 : j - 1;
        p[cnt] = best;
        c[cnt] = (c[j] + c[nb]) >> 1;
        cnt++;
        filled++;
      end
    end
    total = 0;
    for (int i = 0; i < cnt; i++) begin
      total += c[i];
      if (total > TotalMax) total = TotalMax;
    end
    med = 0;
    k = 0;
    if (cnt == 1) begin
      med = p[0] * 2;
    end else begin
      for (int i = 0; i < cnt; i++) begin
        if (p[i] != 0) begin
          v = p[i];
          pos = k;
          while (pos > 0 && srt[pos-1] > v) begin
            srt[pos] = srt[pos-1];
            pos--;
          end
          srt[pos] = v;
          k++;
        end
      end
      if (k > 0) med = (k % 2) ? srt[k/2] * 2 : srt[k/2-1] + srt[k/2];
    end
    r.median_pad_half = med[8:0];
    r.total_charge    = total[TotalW-1:0];
    r.member_count    = cnt > 63 ? 6'd63 : cnt[CntW-1:0];
    r.filled_count    = filled[2:0];
    r.overflow_flag   = dropped;
    return r;
  endfunction

  function automatic void start_cluster(logic [7:0] pad, logic [11:0] chg);
    store_pad[0] = pad;
    store_chg[0] = chg;
    n_members = 1;
    dropped = 0;
  endfunction

  function automatic void take_hit(hit_t h);
    if (!started) begin
      start_cluster(h.hit_pad, h.hit_charge);
      started = 1;
    end else if (gap(h.hit_pad, prev_pad) <= pos_thr &&
                 gap(h.hit_time, prev_time) <= time_thr) begin
      if (n_members < MaxMembers) begin
        store_pad[n_members] = h.hit_pad;
        store_chg[n_members] = h.hit_charge;
        n_members++;
      end else begin
        dropped = 1;
      end
    end else begin
      if (n_members > 0) expected_q = {expected_q, cluster_summary()};
      start_cluster(h.hit_pad, h.hit_charge);
    end
    prev_pad = h.hit_pad;
    prev_time = h.hit_time;
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  function automatic void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (cfg_idx_e'(idx))
      CfgPosThr:  pos_thr = val[7:0];
      CfgTimeThr: time_thr = val;
      CfgMinSize: min_size = val[5:0];
      CfgDeadA:   dead_pad[0] = val[7:0];
      CfgDeadB:   dead_pad[1] = val[7:0];
      CfgDeadC:   dead_pad[2] = val[7:0];
      CfgDeadD:   dead_pad[3] = val[7:0];
      CfgDeadE:   dead_pad[4] = val[7:0];
      default: ;
    endcase
  endfunction

  initial begin
    fails = 0;
    pending_o = 0;
    pos_thr = 10;
    time_thr = 500;
    min_size = 4;
    dead_pad = '{8'd17, 8'd19, 8'd21, 8'd74, 8'd160};
    prev_pad = 0;
    prev_time = 0;
    started = 0;
    n_members = 0;
    dropped = 0;
  end

  always @(posedge clk_i) begin
    result_t want, got;
    if (rst_ni) begin
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_i) take_hit(in_data_i);
      if (out_valid_i && out_ready_i) seen_q = {seen_q, out_data_i};
      // a result beat shows up only after its closing hit is taken; expected results wait in the queue
      while (expected_q.size() > 0 && seen_q.size() > 0) begin
        want = expected_q.pop_front();
        got = seen_q.pop_front();
        if (got.median_pad_half != want.median_pad_half)
          report("median_pad_half", got.median_pad_half, want.median_pad_half);
        if (got.total_charge != want.total_charge)
          report("total_charge", got.total_charge, want.total_charge);
        if (got.member_count != want.member_count)
          report("member_count", got.member_count, want.member_count);
        if (got.filled_count != want.filled_count)
          report("filled_count", got.filled_count, want.filled_count);
        if (got.overflow_flag != want.overflow_flag)
          report("overflow_flag", got.overflow_flag, want.overflow_flag);
      end
      pending_o = expected_q.size();
    end
  end

  always @(posedge drain_i) begin
    if (seen_q.size() > 0) report("unexpected result beats", seen_q.size(), 0);
    if (expected_q.size() > 0) report("missing result beats", 0, expected_q.size());
  end

endmodule

// ===== tb/tb_hit_cluster_builder_top.sv =====
// testbench top for the hit cluster builder: clock, reset, hit stimulus, register writes, result stalls and verdict
`timescale 1ns / 100ps

module tb_hit_cluster_builder_top;
  import hcb_pkg::*;

  localparam int CycleLimit = 4000000;
  localparam int SettleCycles = 400;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  hit_t                in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  result_t             out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                drain;
  int                  pending;
  int                  fail_count;

  bit          rush;
  logic [7:0]  cur_pos_thr;
  logic [15:0] cur_time_thr;
  logic [31:0] clock_now;
  int          hits_sent = 0;
  int          cycles = 0;

  hit_cluster_builder_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o, .out_ready_i,
    .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  hcb_result_check u_check (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .drain_i(drain),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stall before each beat, none while rushing
  initial begin
    int w;
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      w = rush ? 0 : $urandom_range(0, 18);
      if (w > 0) begin
        out_ready_i <= 0;
        repeat (w) @(negedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_hit(logic [7:0] pad, logic [11:0] chg, logic [31:0] stamp);
    int w;
    w = rush ? 0 : $urandom_range(0, 18);
    if (w > 0) begin
      in_valid_i <= 0;
      repeat (w) @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= '{hit_pad: pad, hit_charge: chg, hit_time: stamp};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    hits_sent++;
    clock_now = stamp;
  endtask

  task automatic wait_idle();
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_regs(logic [7:0] pos, logic [15:0] tthr, logic [5:0] msize,
                          logic [7:0] da, logic [7:0] db, logic [7:0] dc,
                          logic [7:0] dd, logic [7:0] de);
    logic [CfgDataW-1:0] vals [8];
    vals = '{pos, tthr, msize, da, db, dc, dd, de};
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1;
      cfg_idx_i <= i[CfgIdxW-1:0];
      cfg_data_i <= vals[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 0;
    cur_pos_thr = pos;
    cur_time_thr = tthr;
  endtask

  // one well-formed cluster followed by whatever comes next
  task automatic send_cluster(logic [7:0] da);
    int len, step;
    int p;
    logic [31:0] t;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
    p = ($urandom_range(0, 1)) ? da + $urandom_range(0, 4) - 2 : $urandom_range(0, 255);
    t = clock_now + cur_time_thr + 1 + $urandom_range(0, 1000);
    if (clock_now > 32'hF000_0000) t = $urandom_range(0, 1000);
    for (int i = 0; i < len; i++) begin
      if (p < 0) p = 0;
      if (p > 255) p = 255;
      send_hit(p[7:0], 12'($urandom_range(0, 4095)), t);
      step = $urandom_range(0, cur_pos_thr);
      p = $urandom_range(0, 1) ? p + step : p - step;
      t = t + $urandom_range(0, cur_time_thr);
    end
  endtask

  task automatic random_phase(int hits, logic [7:0] da);
    int stop;
    stop = hits_sent + hits;
    while (hits_sent < stop) begin
      if ($urandom_range(0, 9) == 0) begin
        send_hit(8'($urandom), 12'($urandom), $urandom);
      end else begin
        send_cluster(da);
      end
    end
  endtask

  initial begin
    rush = 0;
    drain = 0;
    rst_ni = 0;
    in_valid_i = 0;
    in_data_i = '0;
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    cur_pos_thr = 10;
    cur_time_thr = 500;
    clock_now = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed, reset settings
    send_hit(0, 0, 0);
    send_hit(0, 4095, 500);                  // time gap exactly at threshold joins
    send_hit(0, 100, 1001);                  // closes an all-zero-pad cluster
    send_hit(255, 4095, 1001);
    send_hit(16, 7, 32'hFFFF_FFFF);
    send_hit(18, 4095, 32'hFFFF_FE0B);       // time going backwards still joins
    send_hit(20, 0, 32'hFFFF_FE0B);
    send_hit(22, 2048, 32'hFFFF_FE0B);
    send_hit(75, 1, 32'hFFFF_FE0B);          // dead pads filled around 17..21
    send_hit(73, 30, 32'hFFFF_FE0B);
    send_hit(72, 31, 32'hFFFF_FFFF);
    send_hit(75, 5, 0);                      // huge time gap, no wrap
    for (int i = 0; i < 35; i++) send_hit(8'(160 + (i % 3)), 4095, 32'(10 + i));  // store fills
    send_hit(0, 0, 2000);
    send_hit(10, 9, 2000);                   // pad distance exactly at threshold

    rush = 1;
    random_phase(200, 17);
    rush = 0;
    random_phase(200, 74);

    set_regs(10, 500, 4, 17, 19, 21, 74, 160);
    random_phase(150, 160);
    wait_idle();                             // sender holds off until all results are in
    set_regs(0, 0, 2, 0, 1, 255, 254, 128);
    random_phase(250, 1);
    set_regs(255, 16'hFFFF, 32, 100, 100, 101, 102, 103);
    random_phase(200, 101);
    set_regs(3, 100, 0, 50, 52, 54, 56, 58);
    random_phase(250, 54);
    set_regs(6, 1000, 1, 200, 202, 204, 0, 2);
    random_phase(250, 202);
    set_regs(8'($urandom), 16'($urandom_range(0, 2000)), 63, 8'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(200, 30);
    set_regs(8'($urandom_range(1, 12)), 16'($urandom), 6'($urandom_range(2, 6)),
             8, 10, 12, 14, 16);
    rush = 1;
    random_phase(150, 12);
    rush = 0;
    send_hit(0, 0, clock_now + 32'd70000);   // close the last open cluster

    wait_idle();
    drain = 1;
    @(negedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/hcb_pkg.sv
sv/hcb_ram.sv
sv/hcb_datapath.sv
sv/hcb_ctrl.sv
sv/hit_cluster_builder_top.sv
sv/hcb_checker.sv
tb/hcb_checker.sv
tb/tb_hit_cluster_builder_top.sv
